>>> rtl/core/sle_pkg.sv
package sle_pkg;

  localparam int CAPACITY_DEF = 64;

  localparam int KIND_W  = 2;
  localparam int POS_W   = 7;
  localparam int VALUE_W = 32;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 7;

  // operation codes
  localparam logic [KIND_W-1:0] KIND_INSERT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DEL_ALL = 2'd2;
  localparam logic [KIND_W-1:0] KIND_LIST    = 2'd3;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BAD_INS = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BAD_DEL = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic [POS_W-1:0]          position;
    logic signed [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0]         status;
    logic [COUNT_W-1:0]        count;
    logic signed [VALUE_W-1:0] item;
    logic                      last;
  } out_item_t;

endpackage

>>> rtl/core/sequential_list_engine_unit.sv
// ordered list of up to CAPACITY signed 32-bit entries kept in a simple
// dual-port style memory (one read and one write per cycle, registered read
// data). each input item is one operation and the block takes no new item
// until the operation has put its last result into the output register. an
// error item is accepted and then goes straight to loading its result. for
// insert and delete at position p the shift moves one entry per cycle
// through the memory read port, then the last entry read is written back
// and a drain step follows before the result is loaded. delete-all-equal does
// one memory read per entry. listing reads each entry and then loads it into
// the output register; an empty list goes straight to its result. a stall on
// the output side delays the loading of each result until it is taken.
// the entry memory needs no clearing after reset: only entries below the
// fill count are ever read.
module sequential_list_engine_unit #(
  parameter int CAPACITY = sle_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sle_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sle_pkg::out_item_t out_data
);
  import sle_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_MOVE    = 6'b000010,
    ST_DRAIN   = 6'b000100,
    ST_DONE    = 6'b001000,
    ST_LIST_RD = 6'b010000,
    ST_LIST_OT = 6'b100000
  } state_t;

  // entry memory
  logic [VALUE_W-1:0] mem [CAPACITY];
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [VALUE_W-1:0] rd_data_r;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [VALUE_W-1:0] wr_data;

  // control
  state_t             state_r, state_nxt;
  logic [CW-1:0]      fill_r, fill_nxt;
  logic [KIND_W-1:0]  op_r, op_nxt;
  logic               ok_r, ok_nxt;
  logic [STAT_W-1:0]  stat_r, stat_nxt;
  logic [CW-1:0]      src_r, src_nxt;     // next memory address to read
  logic [CW-1:0]      cnt_r, cnt_nxt;     // reads still to issue
  logic [CW-1:0]      wptr_r, wptr_nxt;   // compaction write pointer
  logic               wv_r, wv_nxt;       // a read is in flight, write it back
  logic [AW-1:0]      wa_r, wa_nxt;
  logic               out_valid_r, out_valid_nxt;

  // payload
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [VALUE_W-1:0] val_r, val_nxt;
  out_item_t          out_r, out_nxt;

  logic               out_free;
  logic [POS_W-1:0]   fill_ext;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || out_ready;
  assign fill_ext  = POS_W'(fill_r);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    op_nxt        = op_r;
    ok_nxt        = ok_r;
    stat_nxt      = stat_r;
    src_nxt       = src_r;
    cnt_nxt       = cnt_r;
    wptr_nxt      = wptr_r;
    wv_nxt        = wv_r;
    wa_nxt        = wa_r;
    pos_nxt       = pos_r;
    val_nxt       = val_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    rd_en         = 1'b0;
    rd_addr       = src_r[AW-1:0];
    wr_en         = 1'b0;
    wr_addr       = wa_r;
    wr_data       = rd_data_r;

    // write-back of the entry read in the previous cycle
    if (wv_r && (state_r == ST_MOVE || state_r == ST_DRAIN)) begin
      if (op_r == KIND_DEL_ALL) begin
        if (rd_data_r != val_r) begin
          wr_en    = 1'b1;
          wr_addr  = wptr_r[AW-1:0];
          wptr_nxt = wptr_r + 1'b1;
        end
      end else begin
        wr_en = 1'b1;
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt   = in_data.kind;
          pos_nxt  = in_data.position;
          val_nxt  = in_data.value;
          ok_nxt   = 1'b0;
          stat_nxt = STAT_OK;
          wv_nxt   = 1'b0;
          wptr_nxt = '0;
          unique case (in_data.kind)
            KIND_INSERT: begin
              if (in_data.position > fill_ext) begin
                stat_nxt  = STAT_BAD_INS;
                state_nxt = ST_DONE;
              end else if (fill_r == CW'(CAPACITY)) begin
                stat_nxt  = STAT_FULL;
                state_nxt = ST_DONE;
              end else begin
                // shift entries pos..fill-1 up, highest first
                ok_nxt    = 1'b1;
                src_nxt   = fill_r - 1'b1;
                cnt_nxt   = CW'(fill_ext - in_data.position);
                state_nxt = ST_MOVE;
              end
            end
            KIND_DELETE: begin
              if (in_data.position >= fill_ext) begin
                stat_nxt  = STAT_BAD_DEL;
                state_nxt = ST_DONE;
              end else begin
                // shift entries pos+1..fill-1 down, lowest first
                ok_nxt    = 1'b1;
                src_nxt   = CW'(in_data.position) + 1'b1;
                cnt_nxt   = CW'(fill_ext - in_data.position - 1'b1);
                state_nxt = ST_MOVE;
              end
            end
            KIND_DEL_ALL: begin
              ok_nxt    = 1'b1;
              src_nxt   = '0;
              cnt_nxt   = fill_r;
              state_nxt = ST_MOVE;
            end
            KIND_LIST: begin
              src_nxt = '0;
              cnt_nxt = fill_r;
              if (fill_r == '0) begin
                state_nxt = ST_DONE;
              end else begin
                state_nxt = ST_LIST_RD;
              end
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end

      ST_MOVE: begin
        if (cnt_r != '0) begin
          rd_en   = 1'b1;
          cnt_nxt = cnt_r - 1'b1;
          wv_nxt  = 1'b1;
          if (op_r == KIND_INSERT) begin
            src_nxt = src_r - 1'b1;
            wa_nxt  = AW'(src_r + 1'b1);
          end else begin
            src_nxt = src_r + 1'b1;
            wa_nxt  = AW'(src_r - 1'b1);
          end
        end else begin
          // the last entry read is written back in this cycle
          wv_nxt    = 1'b0;
          state_nxt = ST_DRAIN;
        end
      end

      ST_DRAIN: begin
        wv_nxt    = 1'b0;
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        if (out_free) begin
          if (ok_r) begin
            unique case (op_r)
              KIND_INSERT: begin
                wr_en    = 1'b1;
                wr_addr  = pos_r[AW-1:0];
                wr_data  = val_r;
                fill_nxt = fill_r + 1'b1;
              end
              KIND_DELETE:  fill_nxt = fill_r - 1'b1;
              KIND_DEL_ALL: fill_nxt = wptr_r;
              default:      fill_nxt = fill_r;
            endcase
          end
          out_nxt.status = stat_r;
          out_nxt.count  = COUNT_W'(fill_nxt);
          out_nxt.item   = '0;
          out_nxt.last   = 1'b1;
          out_valid_nxt  = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end

      ST_LIST_RD: begin
        rd_en     = 1'b1;
        src_nxt   = src_r + 1'b1;
        cnt_nxt   = cnt_r - 1'b1;
        state_nxt = ST_LIST_OT;
      end

      ST_LIST_OT: begin
        // rd_data_r holds until the next read, so stalls are safe
        if (out_free) begin
          out_nxt.status = STAT_OK;
          out_nxt.count  = COUNT_W'(fill_r);
          out_nxt.item   = rd_data_r;
          out_nxt.last   = (cnt_r == '0);
          out_valid_nxt  = 1'b1;
          state_nxt      = (cnt_r == '0) ? ST_IDLE : ST_LIST_RD;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      op_r        <= KIND_INSERT;
      ok_r        <= 1'b0;
      stat_r      <= STAT_OK;
      src_r       <= '0;
      cnt_r       <= '0;
      wptr_r      <= '0;
      wv_r        <= 1'b0;
      wa_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      op_r        <= op_nxt;
      ok_r        <= ok_nxt;
      stat_r      <= stat_nxt;
      src_r       <= src_nxt;
      cnt_r       <= cnt_nxt;
      wptr_r      <= wptr_nxt;
      wv_r        <= wv_nxt;
      wa_r        <= wa_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    val_r <= val_nxt;
    out_r <= out_nxt;
  end

endmodule
